// ===== hdl/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 byte stream decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

   localparam int unsigned CP_WIDTH   = 21;
   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned REM_WIDTH  = 3;

   localparam logic [BYTE_WIDTH-1:0] ASCII_MAX = 8'd127;

   // Decoder state carried from one word to the next.
   typedef struct packed {
      logic [REM_WIDTH-1:0] bytes_remaining;
      logic                 discarding;
      logic [CP_WIDTH-1:0]  accumulator;
   } dec_state_type;

endpackage

`default_nettype wire

// ===== hdl/utf8_byte_stream_decoder.sv =====
// Top level of the UTF-8 byte stream decoder: input register, decode step,
// result register. Depends on u8d_pkg and u8d_step.
`timescale 1ns / 1ps
`default_nettype none

// Takes one string byte per word on req_ and returns a 21-bit code point on
// rsp_ whenever a character completes: ASCII bytes come out as themselves,
// 2..4 byte sequences after their last byte. Continuation bytes are not
// checked; stray continuations, 0xFE and 0xFF are dropped, 5/6 byte
// sequences are swallowed whole, and a zero byte clears any pending
// sequence or skip. Throughput is one byte per cycle unless an emitting
// byte meets a full result register that is not taken. The byte lands in
// the input register when accepted, its code point in the result register
// when the byte advances, which a full result register can stall. The rate
// is set by the state loop through the single decode step, which folds one
// byte per cycle into the state as bytes advance. The result register lets
// a byte with no code point pass while a result waits to be taken.
module utf8_byte_stream_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [20:0]      rsp_code_point
);
   import u8d_pkg::*;

   // input register
   logic                  in_valid_ff;
   logic [BYTE_WIDTH-1:0] in_byte_ff;

   // decoder state
   dec_state_type st_ff;
   dec_state_type st_in;

   // result register
   logic                out_valid_ff;
   logic [CP_WIDTH-1:0] out_cp_ff;

   logic                step_emit;
   logic [CP_WIDTH-1:0] step_cp;
   logic                advance;

   u8d_step u_step (
      .state_i    (st_ff),
      .data_byte  (in_byte_ff),
      .state_o    (st_in),
      .emit       (step_emit),
      .code_point (step_cp)
   );

   // a byte moves on unless it emits while the result slot stays full
   assign advance   = in_valid_ff & (~step_emit | ~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         st_ff        <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            st_ff <= st_in;
         end
         if (advance & step_emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_ready & req_valid) begin
         in_byte_ff <= req_data_byte;
      end
      if (advance & step_emit) begin
         out_cp_ff <= step_cp;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_cp_ff;

`ifndef SYNTHESIS
   // a skip always has bytes left to swallow
   a_disc_has_rem : assert property (@(posedge clock) disable iff (reset)
      st_ff.discarding |-> (st_ff.bytes_remaining != '0))
      else $error("discarding set with no bytes remaining");

   // longest pending run is five bytes
   a_rem_range : assert property (@(posedge clock) disable iff (reset)
      st_ff.bytes_remaining <= 3'd5)
      else $error("bytes_remaining out of range");

   // a terminator returns the decoder to idle
   a_zero_clears : assert property (@(posedge clock) disable iff (reset)
      (advance && in_byte_ff == 8'd0) |=>
         (st_ff.bytes_remaining == '0 && !st_ff.discarding && st_ff.accumulator == '0))
      else $error("zero byte did not clear state");

   // an emitted result never gets overwritten before it is taken
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !(advance && step_emit))
      else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ===== hdl/u8d_step.sv =====
// One decode step: next decoder state and optional code point for one byte.
// Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8d_step (
   input  wire u8d_pkg::dec_state_type state_i,
   input  wire logic [7:0]             data_byte,
   output u8d_pkg::dec_state_type      state_o,
   output logic                        emit,
   output logic [20:0]                 code_point
);
   import u8d_pkg::*;

   logic [REM_WIDTH-1:0] rem_dec;
   logic [CP_WIDTH-1:0]  acc_shift;

   assign rem_dec   = state_i.bytes_remaining - 3'd1;
   assign acc_shift = {state_i.accumulator[CP_WIDTH-7:0], data_byte[5:0]};

   always_comb begin
      state_o    = state_i;
      emit       = 1'b0;
      code_point = acc_shift;
      if (data_byte == 8'd0) begin
         // terminator: drop everything pending
         state_o = '0;
      end else if (state_i.bytes_remaining != '0) begin
         state_o.bytes_remaining = rem_dec;
         if (state_i.discarding) begin
            state_o.discarding = (rem_dec != '0);
         end else if (rem_dec == '0) begin
            emit                = 1'b1;
            state_o.accumulator = '0;
         end else begin
            state_o.accumulator = acc_shift;
         end
      end else begin
         state_o.discarding = 1'b0;
         if (data_byte <= ASCII_MAX) begin
            emit       = 1'b1;
            code_point = {{(CP_WIDTH-BYTE_WIDTH){1'b0}}, data_byte};
         end else begin
            unique casez (data_byte)
               8'b110?_???? : begin
                  state_o.accumulator     = {{(CP_WIDTH-5){1'b0}}, data_byte[4:0]};
                  state_o.bytes_remaining = 3'd1;
               end
               8'b1110_???? : begin
                  state_o.accumulator     = {{(CP_WIDTH-4){1'b0}}, data_byte[3:0]};
                  state_o.bytes_remaining = 3'd2;
               end
               8'b1111_0??? : begin
                  state_o.accumulator     = {{(CP_WIDTH-3){1'b0}}, data_byte[2:0]};
                  state_o.bytes_remaining = 3'd3;
               end
               8'b1111_10?? : begin
                  state_o.accumulator     = '0;
                  state_o.bytes_remaining = 3'd4;
                  state_o.discarding      = 1'b1;
               end
               8'b1111_110? : begin
                  state_o.accumulator     = '0;
                  state_o.bytes_remaining = 3'd5;
                  state_o.discarding      = 1'b1;
               end
               default : begin
                  // stray continuation, 0xFE, 0xFF: dropped
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb_utf8_byte_stream_decoder.sv =====
// Self-checking testbench for utf8_byte_stream_decoder: directed and random byte
// streams, predicted code points checked in order against the rsp_ channel.
// Depends on u8d_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_utf8_byte_stream_decoder;
   import u8d_pkg::*;

   localparam int unsigned CLK_PERIOD    = 20;
   localparam int unsigned RESET_CYCLES  = 9;
   // Wait after the last owed code point is back, as margin.
   localparam int unsigned SETTLE_CYCLES = 6;
   // The cutoff bounds even the slowest run (about 750 words, each waiting out
   // sender gaps and receiver stalls).
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned HOLD_CYCLES   = 80;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic [BYTE_WIDTH-1:0] req_data_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [CP_WIDTH-1:0]   rsp_code_point;

   // Traffic shaping, in percent per cycle.
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   // Long receiver hold-off: the test bumps hold_req, the receiver counts.
   int unsigned hold_req  = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_len  = 0;
   int unsigned hold_left = 0;

   int unsigned errors     = 0;
   int unsigned bytes_sent = 0;

   // Decoder state as the testbench sees it, and code points still owed.
   dec_state_type       dec_model = '0;
   logic [CP_WIDTH-1:0] code_point_q[$];
   logic [CP_WIDTH-1:0] expected_cp;

   utf8_byte_stream_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Fold one accepted byte into the decoder state. Returns 1 when a code
   // point completes, with the value in cp.
   function automatic bit decode_byte(input logic [BYTE_WIDTH-1:0] b,
                                      output logic [CP_WIDTH-1:0] cp);
      int                    ones;
      logic [BYTE_WIDTH-1:0] lead_mask;
      cp   = '0;
      ones = 0;
      // Terminator: drop whatever is pending, sequence or skip alike.
      if (b == '0) begin
         dec_model = '0;
         return 1'b0;
      end
      if (dec_model.bytes_remaining != '0) begin
         dec_model.bytes_remaining = dec_model.bytes_remaining - 1'b1;
         if (dec_model.discarding) begin
            if (dec_model.bytes_remaining == '0)
               dec_model.discarding = 1'b0;
            return 1'b0;
         end
         // Any nonzero byte counts as a continuation; only low six bits used.
         dec_model.accumulator = {dec_model.accumulator[CP_WIDTH-7:0], b[5:0]};
         if (dec_model.bytes_remaining == '0) begin
            cp = dec_model.accumulator;
            dec_model.accumulator = '0;
            return 1'b1;
         end
         return 1'b0;
      end
      dec_model.discarding = 1'b0;
      if (b <= ASCII_MAX) begin
         cp = CP_WIDTH'(b);
         return 1'b1;
      end
      while (ones < 8 && b[7-ones])
         ones++;
      // Stray continuation (one leading one), 0xFE and 0xFF: dropped.
      if (ones <= 1 || ones >= 7)
         return 1'b0;
      dec_model.bytes_remaining = REM_WIDTH'(ones - 1);
      if (ones <= 4) begin
         lead_mask = 8'hFF >> (ones + 1);
         dec_model.accumulator = CP_WIDTH'(b & lead_mask);
         dec_model.discarding  = 1'b0;
      end else begin
         // 5 and 6 byte leads: swallow the rest of the sequence.
         dec_model.accumulator = '0;
         dec_model.discarding  = 1'b1;
      end
      return 1'b0;
   endfunction

   // Offer one word, after a random idle gap, and wait for the handshake.
   // Valid stays high when the next word follows without a gap.
   task automatic send_byte(input logic [BYTE_WIDTH-1:0] b);
      logic [CP_WIDTH-1:0] cp;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      if (decode_byte(b, cp))
         code_point_q = {code_point_q, cp};
      bytes_sent++;
   endtask

   // Sender goes quiet until every owed code point is back, then settles.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (code_point_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly 10xxxxxx; now and then any nonzero byte, which is taken anyway.
   function automatic logic [BYTE_WIDTH-1:0] rand_cont();
      if ($urandom_range(9) == 0)
         return BYTE_WIDTH'($urandom_range(1, 255));
      return {2'b10, 6'($urandom_range(0, 63))};
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] lead_byte(input int unsigned n);
      case (n)
         2:       return {3'b110,   5'($urandom_range(0, 31))};
         3:       return {4'b1110,  4'($urandom_range(0, 15))};
         default: return {5'b11110, 3'($urandom_range(0, 7))};
      endcase
   endfunction

   // One random character; mostly well formed, the rest noise.
   task automatic send_random_char();
      int unsigned pick;
      int unsigned n;
      int unsigned k;
      pick = $urandom_range(99);
      if (pick < 30) begin
         send_byte(BYTE_WIDTH'($urandom_range(1, 127)));
      end else if (pick < 78) begin
         n = (pick < 50) ? 2 : (pick < 65) ? 3 : 4;
         send_byte(lead_byte(n));
         for (k = 1; k < n; k++)
            send_byte(rand_cont());
      end else if (pick < 87) begin
         // Skipped 5/6 byte sequence; body bytes are any nonzero value.
         n = (pick < 83) ? 5 : 6;
         if (n == 5)
            send_byte({6'b111110, 2'($urandom_range(0, 3))});
         else
            send_byte({7'b1111110, 1'($urandom_range(0, 1))});
         for (k = 1; k < n; k++)
            send_byte(BYTE_WIDTH'($urandom_range(1, 255)));
      end else if (pick < 91) begin
         send_byte(8'h00);
      end else if (pick < 95) begin
         // Cut short: whatever nonzero byte comes next is eaten as continuation.
         n = $urandom_range(2, 4);
         send_byte(lead_byte(n));
         k = $urandom_range(0, n - 2);
         repeat (k) send_byte(rand_cont());
      end else begin
         send_byte(BYTE_WIDTH'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_ascii();
      send_byte(8'h01);
      send_byte(8'h7F);
      wait_for_results();
   endtask

   task automatic test_multibyte();
      send_byte(8'hDF); send_byte(8'hBF);
      send_byte(8'hE0); send_byte(8'h80); send_byte(8'h80);
      // Largest code point the 21-bit result can carry.
      send_byte(8'hF7); send_byte(8'hBF); send_byte(8'hBF); send_byte(8'hBF);
      wait_for_results();
   endtask

   task automatic test_dropped_bytes();
      send_byte(8'h80);
      send_byte(8'hFE);
      send_byte(8'hFF);
      wait_for_results();
   endtask

   task automatic test_long_skip();
      send_byte(8'hF8);
      send_byte(8'h01); send_byte(8'h02); send_byte(8'h03); send_byte(8'h04);
      send_byte(8'h41);
      wait_for_results();
   endtask

   task automatic test_terminator();
      // Zero mid-sequence, then zero mid-skip.
      send_byte(8'hE2); send_byte(8'h82); send_byte(8'h00);
      send_byte(8'hFC); send_byte(8'h80); send_byte(8'h00);
      wait_for_results();
   endtask

   task automatic test_unchecked_continuation();
      send_byte(8'hC3); send_byte(8'h41);
      wait_for_results();
   endtask

   // Receiver holds off for a long stretch while ASCII words keep coming,
   // so the block fills and drops req_ready.
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_len <= HOLD_CYCLES;
      hold_req <= hold_req + 1;
      repeat (40) send_byte(BYTE_WIDTH'($urandom_range(1, 127)));
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int unsigned idle_pct,
                                      input int unsigned stall_pct,
                                      input int unsigned count);
      int unsigned start;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      start = bytes_sent;
      while (bytes_sent - start < count)
         send_random_char();
      wait_for_results();
   endtask

   // Receiver: random stalls, or a counted hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_left <= hold_len;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Each accepted result word against the oldest owed code point.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (code_point_q.size() == 0) begin
            $display("%0t: unexpected code point: expected none, got %h",
                     $time, rsp_code_point);
            errors++;
         end else begin
            expected_cp = code_point_q.pop_front();
            if (rsp_code_point !== expected_cp) begin
               $display("%0t: code point mismatch: expected %h, got %h",
                        $time, expected_cp, rsp_code_point);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[utf8_byte_stream_decoder] ERROR");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ascii();
      test_multibyte();
      test_dropped_bytes();
      test_long_skip();
      test_terminator();
      test_unchecked_continuation();
      test_backpressure();
      test_random_traffic(0, 0, 170);
      test_random_traffic(75, 0, 170);
      test_random_traffic(0, 75, 170);
      test_random_traffic(17, 17, 170);

      if (code_point_q.size() != 0)
         $display("%0t: %0d code points never arrived, first expected %h",
                  $time, code_point_q.size(), code_point_q[0]);
      if (errors == 0 && code_point_q.size() == 0)
         $display("[utf8_byte_stream_decoder] OK");
      else
         $display("[utf8_byte_stream_decoder] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/u8d_pkg.sv
hdl/u8d_step.sv
hdl/utf8_byte_stream_decoder.sv
tb/tb_utf8_byte_stream_decoder.sv
